@@ src/sorted_chain_hash_table_unit_assert.svh @@
// Assertion macros used by the hash table unit checker.
`ifndef SORTED_CHAIN_HASH_TABLE_UNIT_ASSERT_SVH
`define SORTED_CHAIN_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SCH_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hash table unit check failed");

// Next-cycle implication, disabled while reset is high.
`define SCH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hash table unit check failed");

`endif

@@ src/sch_pkg.sv @@
// Shared constants, codes and helpers of the sorted chain hash table unit.
`timescale 1ns / 1ps
package sch_pkg;
   localparam int BUCKETS_DEFAULT = 1024;
   localparam int NODES_DEFAULT   = 1024;

   // field widths
   localparam int CFG_W  = 11;
   localparam int CMD_W  = 2;
   localparam int KH_W   = 64;
   localparam int KL_W   = 16;
   localparam int REC_W  = 10;
   localparam int STAT_W = 2;
   localparam int REQ_W  = 96;
   localparam int RSP_W  = 16;

   localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 11'd1021;

   // hash arithmetic widths: sum of 8 weighted character values
   localparam int SUM_W = 14;
   localparam int MAG_W = 13;
   localparam int REM_W = 12;

   localparam logic [7:0] CHAR_LIMIT        = 8'd59;
   localparam logic [9:0] CHAR_OFFSET_DIGIT = 10'd48;
   localparam logic [9:0] CHAR_OFFSET_ALPHA = 10'd54;

   // commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

   // character value used by the bucket hash
   function automatic logic signed [9:0] char_value(input logic [7:0] c);
      logic [9:0] ce;
      ce = {2'b00, c};
      if (c < CHAR_LIMIT) begin
         char_value = signed'(ce - CHAR_OFFSET_DIGIT);
      end else begin
         char_value = signed'(ce - CHAR_OFFSET_ALPHA);
      end
   endfunction
endpackage

@@ src/sorted_chain_hash_table_unit.sv @@
// Top level of the sorted chain hash table unit.
// Channel | Dir | Signals                     | Contents
// csr     | in  | csr_valid/ready/data        | bucket_count write
// req     | in  | req_tvalid/tready/tdata     | command, key, record
// rsp     | out | rsp_tvalid/tready/tdata     | status, found_record
// After reset a clearing pass empties the bucket heads; no request is taken
// meanwhile. A request then hashes its key (hash modulo: one bit per cycle),
// walks its chain node by node (each walk step is one node memory read and
// compare), then relinks nodes for an insert or a remove.
// A finished response waits in the output register; the next request is taken
// while it waits.
`timescale 1ns / 1ps
module sorted_chain_hash_table_unit #(
   parameter int BUCKETS = sch_pkg::BUCKETS_DEFAULT,
   parameter int NODES   = sch_pkg::NODES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sch_pkg::CFG_W-1:0]  csr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // command[1:0], key_high[65:2], key_low[81:66], record_number[91:82], zero[95:92]
   input  logic [sch_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[1:0], found_record[11:2], zero[15:12]
   output logic [sch_pkg::RSP_W-1:0]  rsp_tdata
);
   localparam int BIW = $clog2(BUCKETS);
   localparam int NIW = $clog2(NODES);
   localparam int PW  = $clog2(NODES + 1);
   localparam int DW  = sch_pkg::KH_W + sch_pkg::KL_W + sch_pkg::REC_W;
   localparam int KW  = sch_pkg::KH_W + sch_pkg::KL_W;
   localparam logic [PW-1:0] NIL = PW'(NODES);

   typedef enum logic [13:0] {
      S_CLEAR = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_DIV   = 14'b00000000000100,
      S_FIX   = 14'b00000000001000,
      S_HEADW = 14'b00000000010000,
      S_CHK   = 14'b00000000100000,
      S_CMP   = 14'b00000001000000,
      S_ACT   = 14'b00000010000000,
      S_FREE  = 14'b00000100000000,
      S_INS1  = 14'b00001000000000,
      S_INS2  = 14'b00010000000000,
      S_REM1  = 14'b00100000000000,
      S_REM2  = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // memories
   logic [PW-1:0] head_mem [BUCKETS];
   logic [PW-1:0] next_mem [NODES];
   logic [DW-1:0] data_mem [NODES];
   logic [PW-1:0] head_q, next_q;
   logic [DW-1:0] data_q;

   logic           head_we, next_we, data_we;
   logic [BIW-1:0] head_wa, head_ra;
   logic [PW-1:0]  head_wd;
   logic [NIW-1:0] next_wa, next_ra, data_wa, data_ra;
   logic [PW-1:0]  next_wd;

   // control and payload registers
   logic [sch_pkg::CFG_W-1:0]  bc_ff;
   logic [BIW-1:0]             clr_ff, clr_in;
   logic [sch_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [KW-1:0]              key_ff, key_in;
   logic [sch_pkg::REC_W-1:0]  rec_ff, rec_in;
   logic [sch_pkg::MAG_W-1:0]  mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [sch_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [3:0]                 cnt_ff, cnt_in;
   logic [BIW-1:0]             bidx_ff, bidx_in;
   logic [PW-1:0]              cur_ff, cur_in, prev_ff, prev_in, steps_ff, steps_in;
   logic [PW-1:0]              curnext_ff, curnext_in, nd_ff, nd_in;
   logic [PW-1:0]              free_ff, free_in, fresh_ff, fresh_in;
   logic                       match_ff, match_in;
   logic [sch_pkg::REC_W-1:0]  currec_ff, currec_in, found_ff, found_in;
   logic [sch_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [sch_pkg::RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic signed [sch_pkg::SUM_W-1:0] sum;
   logic [sch_pkg::CFG_W-1:0]        n_eff;
   logic [sch_pkg::REM_W-1:0]        trial, rfix;
   logic [KW-1:0]                    node_key;
   logic                             req_fire;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign node_key   = data_q[DW-1:sch_pkg::REC_W];

   // weighted character sum of the request key_high
   always_comb begin
      logic signed [sch_pkg::SUM_W-1:0] fv;
      sum = '0;
      for (int i = 0; i < 8; i++) begin
         fv  = sch_pkg::SUM_W'(sch_pkg::char_value(req_tdata[65 - 8 * i -: 8]));
         sum = sum + fv * sch_pkg::SUM_W'(i + 1);
      end
   end

   // clamp the bucket count to between one and the table size
   always_comb begin
      if (bc_ff == '0) begin
         n_eff = sch_pkg::CFG_W'(1);
      end else if (32'(bc_ff) > BUCKETS) begin
         n_eff = sch_pkg::CFG_W'(BUCKETS);
      end else begin
         n_eff = bc_ff;
      end
   end

   // one restoring remainder step, and the floored fix of a negative sum
   always_comb begin
      logic [sch_pkg::REM_W-1:0] t;
      t = {rem_ff[sch_pkg::REM_W-2:0], mag_ff[sch_pkg::MAG_W-1]};
      if (t >= sch_pkg::REM_W'(n_eff)) begin
         trial = t - sch_pkg::REM_W'(n_eff);
      end else begin
         trial = t;
      end
      if (neg_ff && rem_ff != '0) begin
         rfix = sch_pkg::REM_W'(n_eff) - rem_ff;
      end else begin
         rfix = rem_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      rec_in       = rec_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      bidx_in      = bidx_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      curnext_in   = curnext_ff;
      nd_in        = nd_ff;
      free_in      = free_ff;
      fresh_in     = fresh_ff;
      match_in     = match_ff;
      currec_in    = currec_ff;
      found_in     = found_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      head_we = 1'b0; head_wa = bidx_ff; head_wd = NIL; head_ra = bidx_ff;
      next_we = 1'b0; next_wa = nd_ff[NIW-1:0]; next_wd = cur_ff;
      next_ra = free_ff[NIW-1:0];
      data_we = 1'b0; data_wa = nd_ff[NIW-1:0]; data_ra = cur_ff[NIW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            head_wd = NIL;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == BIW'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tdata[1:0];
               // key_high above key_low, so the compare orders by key_high first
               key_in   = {req_tdata[65:2], req_tdata[81:66]};
               rec_in   = req_tdata[91:82];
               neg_in   = sum < 0;
               mag_in   = sch_pkg::MAG_W'(sum < 0 ? -sum : sum);
               rem_in   = '0;
               cnt_in   = '0;
               found_in = '0;
               stat_in  = sch_pkg::ST_NOT_FOUND;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = trial;
            mag_in = {mag_ff[sch_pkg::MAG_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'(sch_pkg::MAG_W - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            bidx_in  = BIW'(32'(rfix));
            head_ra  = BIW'(32'(rfix));
            state_in = S_HEADW;
         end
         S_HEADW: begin
            cur_in   = head_q;
            prev_in  = NIL;
            steps_in = '0;
            state_in = S_CHK;
         end
         S_CHK: begin
            // stop at end of chain or at the step bound, else fetch the node
            if (cur_ff == NIL || steps_ff == NIL) begin
               match_in = 1'b0;
               state_in = S_ACT;
            end else begin
               data_ra  = cur_ff[NIW-1:0];
               next_ra  = cur_ff[NIW-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (node_key < key_ff) begin
               prev_in  = cur_ff;
               cur_in   = next_q;
               steps_in = steps_ff + 1'b1;
               state_in = S_CHK;
            end else begin
               match_in   = node_key == key_ff;
               curnext_in = next_q;
               currec_in  = data_q[sch_pkg::REC_W-1:0];
               state_in   = S_ACT;
            end
         end
         S_ACT: begin
            state_in = S_DONE;
            case (cmd_ff)
               sch_pkg::CMD_INSERT: begin
                  if (match_ff) begin
                     stat_in = sch_pkg::ST_DUPLICATE;
                  end else if (free_ff != NIL) begin
                     next_ra  = free_ff[NIW-1:0];
                     nd_in    = free_ff;
                     state_in = S_FREE;
                  end else if (fresh_ff != NIL) begin
                     nd_in    = fresh_ff;
                     fresh_in = fresh_ff + 1'b1;
                     state_in = S_INS1;
                  end else begin
                     stat_in = sch_pkg::ST_FULL;
                  end
               end
               sch_pkg::CMD_LOOKUP: begin
                  if (match_ff) begin
                     stat_in  = sch_pkg::ST_DONE;
                     found_in = currec_ff;
                  end
               end
               sch_pkg::CMD_REMOVE: begin
                  if (match_ff) begin
                     state_in = S_REM1;
                  end
               end
               default: begin
                  stat_in = sch_pkg::ST_NOT_FOUND;
               end
            endcase
         end
         S_FREE: begin
            // pop the free list
            free_in  = next_q;
            state_in = S_INS1;
         end
         S_INS1: begin
            data_we = 1'b1;
            data_wa = nd_ff[NIW-1:0];
            next_we = 1'b1;
            next_wa = nd_ff[NIW-1:0];
            next_wd = cur_ff;
            stat_in = sch_pkg::ST_DONE;
            if (prev_ff == NIL) begin
               head_we  = 1'b1;
               head_wa  = bidx_ff;
               head_wd  = nd_ff;
               state_in = S_DONE;
            end else begin
               state_in = S_INS2;
            end
         end
         S_INS2: begin
            next_we  = 1'b1;
            next_wa  = prev_ff[NIW-1:0];
            next_wd  = nd_ff;
            state_in = S_DONE;
         end
         S_REM1: begin
            // unlink the node
            if (prev_ff == NIL) begin
               head_we = 1'b1;
               head_wa = bidx_ff;
               head_wd = curnext_ff;
            end else begin
               next_we = 1'b1;
               next_wa = prev_ff[NIW-1:0];
               next_wd = curnext_ff;
            end
            state_in = S_REM2;
         end
         S_REM2: begin
            // push the node on the free list
            next_we  = 1'b1;
            next_wa  = cur_ff[NIW-1:0];
            next_wd  = free_ff;
            free_in  = cur_ff;
            stat_in  = sch_pkg::ST_DONE;
            found_in = currec_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, found_ff, stat_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_q <= head_mem[head_ra];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      next_q <= next_mem[next_ra];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= {key_ff, rec_ff};
      end
      data_q <= data_mem[data_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         bc_ff        <= sch_pkg::BUCKET_COUNT_RESET;
         free_ff      <= NIL;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            bc_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      rec_ff      <= rec_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      bidx_ff     <= bidx_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      steps_ff    <= steps_in;
      curnext_ff  <= curnext_in;
      nd_ff       <= nd_in;
      match_ff    <= match_in;
      currec_ff   <= currec_in;
      found_ff    <= found_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

@@ src/sch_checker.sv @@
// Port-level checker of the hash table unit, with its bind.
`timescale 1ns / 1ps
`include "sorted_chain_hash_table_unit_assert.svh"
module sch_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [sch_pkg::RSP_W-1:0] rsp_tdata
);
   // hold a stalled response
   `SCH_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // busy right after a request is taken
   `SCH_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)
   // no request taken right after reset, at the start of the clearing pass
   `SCH_ASSERT_NOW(a_clear_after_reset, $past(reset), !req_tready)
   // a record is reported only with success
   `SCH_ASSERT_NOW(a_found_zero, rsp_tvalid && rsp_tdata[1:0] != sch_pkg::ST_DONE,
      rsp_tdata[11:2] == 10'd0)
endmodule

bind sorted_chain_hash_table_unit sch_checker u_sch_checker (.*);

@@ tb/tb_sorted_chain_hash_table_unit.sv @@
// Self-checking testbench for the sorted chain hash table unit.
`timescale 1ns / 1ps
module tb_sorted_chain_hash_table_unit;
   localparam int NODE_CNT = 1024;
   localparam int HEAD_CNT = 1024;
   localparam logic [10:0] NIL = 11'd1024;
   localparam logic [sch_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int POOL = 64;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [sch_pkg::CMD_W-1:0] cmd;
      logic [sch_pkg::KH_W-1:0]  kh;
      logic [sch_pkg::KL_W-1:0]  kl;
      logic [sch_pkg::REC_W-1:0] rec;
   } table_req_type;

   typedef struct packed {
      logic [sch_pkg::STAT_W-1:0] status;
      logic [sch_pkg::REC_W-1:0]  rec;
   } table_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sch_pkg::CFG_W-1:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [sch_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [sch_pkg::RSP_W-1:0] rsp_tdata;

   sorted_chain_hash_table_unit DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // shadow copy of the table
   logic [sch_pkg::CFG_W-1:0]  shadow_buckets;
   logic [10:0]                shadow_head [HEAD_CNT];
   logic [sch_pkg::KH_W-1:0]   shadow_kh [NODE_CNT];
   logic [sch_pkg::KL_W-1:0]   shadow_kl [NODE_CNT];
   logic [sch_pkg::REC_W-1:0]  shadow_rec [NODE_CNT];
   logic [10:0]                shadow_next [NODE_CNT];
   logic [10:0]                shadow_free;
   int                         shadow_fresh;

   table_req_type pending_reqs [$];
   table_rsp_type expected_rsps [$];
   int  mismatches = 0;
   int  accepted_reqs = 0;
   int  cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  steady = 1'b0;
   logic [sch_pkg::KH_W-1:0] pool_kh [POOL];
   logic [sch_pkg::KL_W-1:0] pool_kl [POOL];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [10:0] bucket_index(logic [sch_pkg::KH_W-1:0] kh);
      int sum, n, r, c;
      sum = 0;
      for (int i = 0; i < 8; i++) begin
         c = kh[63-8*i -: 8];
         sum += (i + 1) * ((c < 59) ? c - 48 : c - 54);
      end
      n = shadow_buckets;
      if (n < 1) n = 1;
      if (n > HEAD_CNT) n = HEAD_CNT;
      r = sum % n;
      if (r < 0) r += n;
      return r[10:0];
   endfunction

   // apply one request to the shadow table and return its response
   function automatic table_rsp_type table_apply(table_req_type rq);
      table_rsp_type rs;
      logic [10:0] b, prev, cur, nd;
      int steps;
      bit hit;
      rs.status = sch_pkg::ST_NOT_FOUND;
      rs.rec = '0;
      b = bucket_index(rq.kh);
      prev = NIL;
      cur = shadow_head[b];
      steps = 0;
      while (cur < NIL && steps < NODE_CNT &&
             {shadow_kh[cur], shadow_kl[cur]} < {rq.kh, rq.kl}) begin
         prev = cur;
         cur = shadow_next[cur];
         steps++;
      end
      hit = cur < NIL && shadow_kh[cur] == rq.kh && shadow_kl[cur] == rq.kl;
      case (rq.cmd)
         sch_pkg::CMD_INSERT: begin
            if (hit) begin
               rs.status = sch_pkg::ST_DUPLICATE;
            end else begin
               nd = NIL;
               if (shadow_free < NIL) begin
                  nd = shadow_free;
                  shadow_free = shadow_next[nd];
               end else if (shadow_fresh < NODE_CNT) begin
                  nd = shadow_fresh[10:0];
                  shadow_fresh++;
               end
               if (nd < NIL) begin
                  shadow_kh[nd] = rq.kh;
                  shadow_kl[nd] = rq.kl;
                  shadow_rec[nd] = rq.rec;
                  shadow_next[nd] = cur;
                  if (prev < NIL) shadow_next[prev] = nd;
                  else shadow_head[b] = nd;
                  rs.status = sch_pkg::ST_DONE;
               end else begin
                  rs.status = sch_pkg::ST_FULL;
               end
            end
         end
         sch_pkg::CMD_LOOKUP: begin
            if (hit) begin
               rs.status = sch_pkg::ST_DONE;
               rs.rec = shadow_rec[cur];
            end
         end
         sch_pkg::CMD_REMOVE: begin
            if (hit) begin
               if (prev < NIL) shadow_next[prev] = shadow_next[cur];
               else shadow_head[b] = shadow_next[cur];
               rs.rec = shadow_rec[cur];
               shadow_next[cur] = shadow_free;
               shadow_free = cur;
               rs.status = sch_pkg::ST_DONE;
            end
         end
         default: ;
      endcase
      return rs;
   endfunction

   // accept requests and predict their responses
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         expected_rsps.push_back(table_apply(pending_reqs.pop_front()));
         accepted_reqs <= accepted_reqs + 1;
         req_tvalid <= 1'b0;
      end
   end

   // offer the next request
   always @(negedge clock) begin
      if (!reset && !req_tvalid && pending_reqs.size() > 0 &&
          (steady || $urandom_range(99) >= 33)) begin
         req_tvalid <= 1'b1;
         req_tdata <= {4'b0, pending_reqs[0].rec, pending_reqs[0].kl,
                       pending_reqs[0].kh, pending_reqs[0].cmd};
      end
   end

   // long receiver hold once traffic is flowing
   always @(posedge clock) begin
      if (accepted_reqs == 150 && !hold_done) begin
         hold_left <= 500;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && hold_left == 0 && (steady || $urandom_range(99) >= 33);
   end

   // check responses against the oldest prediction
   always @(posedge clock) begin
      table_rsp_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tdata[1:0] !== want.status || rsp_tdata[11:2] !== want.rec) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: status exp %0d got %0d, record exp %0d got %0d",
                           want.status, rsp_tdata[1:0], want.rec, rsp_tdata[11:2]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [7:0] alnum_char();
      int v;
      v = $urandom_range(35);
      return (v < 10) ? 8'd48 + v[7:0] : 8'd55 + v[7:0];
   endfunction

   function automatic logic [sch_pkg::KH_W-1:0] alnum_high();
      logic [sch_pkg::KH_W-1:0] k;
      for (int i = 0; i < 8; i++) k[8*i +: 8] = alnum_char();
      return k;
   endfunction

   task automatic push_req(logic [sch_pkg::CMD_W-1:0] cmd, logic [sch_pkg::KH_W-1:0] kh,
                           logic [sch_pkg::KL_W-1:0] kl, logic [sch_pkg::REC_W-1:0] rec);
      table_req_type rq;
      rq.cmd = cmd; rq.kh = kh; rq.kl = kl; rq.rec = rec;
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_buckets(logic [sch_pkg::CFG_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      shadow_buckets = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly pool keys, some fully random keys as noise
   task automatic push_random(int count);
      int j, pick;
      logic [sch_pkg::CMD_W-1:0] cmd;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         cmd = (pick < 45) ? sch_pkg::CMD_INSERT : (pick < 75) ? sch_pkg::CMD_LOOKUP :
               (pick < 97) ? sch_pkg::CMD_REMOVE : CMD_UNUSED;
         j = $urandom_range(POOL - 1);
         if ($urandom_range(19) == 0)
            push_req(cmd, {$urandom, $urandom}, 16'($urandom), 10'($urandom));
         else
            push_req(cmd, pool_kh[j], pool_kl[j], 10'($urandom));
      end
   endtask

   initial begin
      logic [sch_pkg::CFG_W-1:0] settings [6];
      shadow_buckets = sch_pkg::BUCKET_COUNT_RESET;
      foreach (shadow_head[i]) shadow_head[i] = NIL;
      foreach (shadow_next[i]) begin
         shadow_next[i] = '0; shadow_kh[i] = '0; shadow_kl[i] = '0; shadow_rec[i] = '0;
      end
      shadow_free = NIL;
      shadow_fresh = 0;
      // key pool: some keys share the high part, a few use any byte value
      for (int j = 0; j < POOL; j++) begin
         pool_kh[j] = (j % 4 == 1) ? pool_kh[j-1] :
                      (j >= 56) ? {$urandom, $urandom} : alnum_high();
         pool_kl[j] = (j >= 56) ? 16'($urandom) : {alnum_char(), alnum_char()};
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every command, duplicate, missing, unused command
      push_req(sch_pkg::CMD_INSERT, '0, '0, '0);
      push_req(sch_pkg::CMD_INSERT, '1, '1, '1);
      push_req(sch_pkg::CMD_INSERT, '1, 16'hFFFE, 10'd5);
      push_req(sch_pkg::CMD_INSERT, "ZZZZZZZZ", "ZZ", 10'd700);
      push_req(sch_pkg::CMD_INSERT, "00000000", "00", 10'd1);
      push_req(sch_pkg::CMD_INSERT, "00000000", "01", 10'd2);
      push_req(sch_pkg::CMD_INSERT, '0, '0, 10'd9);
      push_req(sch_pkg::CMD_LOOKUP, '0, '0, '1);
      push_req(sch_pkg::CMD_LOOKUP, '1, '1, '0);
      push_req(sch_pkg::CMD_LOOKUP, '1, 16'hFFFE, '0);
      push_req(sch_pkg::CMD_LOOKUP, "00000000", "02", '0);
      push_req(sch_pkg::CMD_REMOVE, "00000000", "00", '0);
      push_req(sch_pkg::CMD_REMOVE, "00000000", "00", '0);
      push_req(sch_pkg::CMD_LOOKUP, "00000000", "01", '0);
      push_req(CMD_UNUSED, "ZZZZZZZZ", "ZZ", '1);
      push_req(sch_pkg::CMD_REMOVE, '1, '1, '0);
      push_req(sch_pkg::CMD_INSERT, "00000000", "00", 10'd512);
      push_req(sch_pkg::CMD_LOOKUP, "ZZZZZZZZ", "ZZ", '0);
      // hold the sender until every response is back
      wait_idle();

      settings = '{11'd1, 11'd0, 11'd2047, 11'd1024, 11'd7, 11'd1021};
      push_random(100);
      foreach (settings[p]) begin
         write_buckets(settings[p]);
         steady = (p == 2);
         push_random(90);
         if (p == 3) begin
            wait_idle();
            push_random(20);
         end
      end

      // grow the table with many new keys, then recycle some nodes
      write_buckets(11'd1024);
      steady = 1'b0;
      for (int i = 0; i < 200; i++)
         push_req(sch_pkg::CMD_INSERT, alnum_high(), 16'h8000 | i[15:0], 10'($urandom));
      for (int i = 0; i < 20; i++)
         push_req(sch_pkg::CMD_REMOVE, '0, '0, '0);
      push_random(20);
      for (int i = 0; i < 20; i++)
         push_req(sch_pkg::CMD_INSERT, alnum_high(), 16'h4000 | i[15:0], 10'($urandom));
      wait_idle();
      if (expected_rsps.size() == 0 && mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+src
src/sch_pkg.sv
src/sorted_chain_hash_table_unit.sv
src/sch_checker.sv
tb/tb_sorted_chain_hash_table_unit.sv
